>>> rtl/ycc420_pkg.sv
// Shared constants and types for the RGB to YCbCr 4:2:0 downsampler.
package ycc420_pkg;

    localparam int PIX_W             = 8;    // width of one colour component
    localparam int WIDTH_W           = 13;   // width of the image_width register
    localparam int RESET_WIDTH       = 640;  // image_width after reset
    localparam int DEF_MAX_WIDTH     = 4096;
    localparam int DEF_FRACTION_BITS = 16;
    localparam int SUM_W             = PIX_W + 1;  // one pair sum of a chroma channel
    localparam int LINE_W            = 2 * SUM_W;  // Cr pair sum above Cb pair sum

    // Load enables for the two arithmetic stages of the colour converter
    typedef struct packed {
        logic prod_load;
        logic res_load;
    } t_stage_en;

    // Position of a pixel within its 2x2 block
    typedef struct packed {
        logic col_odd;   // odd column: closes a horizontal pair
        logic pair;      // pair lies inside the line store
        logic row_odd;   // odd row: closes the block
    } t_pos;

endpackage

>>> rtl/ycc420_pix_if.sv
// Pixel input channel: valid/ready handshake carrying one RGB pixel per beat.
interface ycc420_pix_if import ycc420_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_start;

    modport source (output valid, output red, output green, output blue,
                    output frame_start, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_start, output ready);
endinterface

>>> rtl/ycc420_res_if.sv
// Result output channel: valid/ready handshake carrying luma and block chroma per beat.
interface ycc420_res_if import ycc420_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] luma;
    logic             chroma_valid;
    logic [PIX_W-1:0] cb_average;
    logic [PIX_W-1:0] cr_average;

    modport source (output valid, output luma, output chroma_valid,
                    output cb_average, output cr_average, input ready);
    modport sink   (input valid, input luma, input chroma_valid,
                    input cb_average, input cr_average, output ready);
endinterface

>>> rtl/ycc420_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module ycc420_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ycc420_csc.sv
// Two-stage fixed-point RGB to full-range YCbCr colour converter.
module ycc420_csc import ycc420_pkg::*; #(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic             i_clk,
    input  t_stage_en        i_en,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    output logic [PIX_W-1:0] o_luma,
    output logic [PIX_W-1:0] o_cb,
    output logic [PIX_W-1:0] o_cr
);

    localparam int KW = FRACTION_BITS;          // every coefficient is below one
    localparam int PW = FRACTION_BITS + PIX_W;  // one product
    localparam int SW = FRACTION_BITS + 10;     // sum of three terms with headroom
    localparam int IW = SW - FRACTION_BITS;     // integer part of a sum

    localparam logic [KW-1:0] K_YR  = KW'(((64'd2990 << FRACTION_BITS) + 64'd5000) / 64'd10000);
    localparam logic [KW-1:0] K_YG  = KW'(((64'd5870 << FRACTION_BITS) + 64'd5000) / 64'd10000);
    localparam logic [KW-1:0] K_YB  = KW'(((64'd1140 << FRACTION_BITS) + 64'd5000) / 64'd10000);
    localparam logic [KW-1:0] K_CBR = KW'(((64'd1687 << FRACTION_BITS) + 64'd5000) / 64'd10000);
    localparam logic [KW-1:0] K_CBG = KW'(((64'd3313 << FRACTION_BITS) + 64'd5000) / 64'd10000);
    localparam logic [KW-1:0] K_HALF = KW'(((64'd5000 << FRACTION_BITS) + 64'd5000) / 64'd10000);
    localparam logic [KW-1:0] K_CRG = KW'(((64'd4187 << FRACTION_BITS) + 64'd5000) / 64'd10000);
    localparam logic [KW-1:0] K_CRB = KW'(((64'd813 << FRACTION_BITS) + 64'd5000) / 64'd10000);
    localparam logic [SW-1:0] OFFSET = SW'(128) << FRACTION_BITS;

    function automatic logic [PIX_W-1:0] f_sat(input logic [IW-1:0] v);
        return (v > IW'(255)) ? {PIX_W{1'b1}} : v[PIX_W-1:0];
    endfunction

    logic [PW-1:0] r_p_yr, r_p_yg, r_p_yb;
    logic [PW-1:0] r_p_cbr, r_p_cbg, r_p_cbb;
    logic [PW-1:0] r_p_crr, r_p_crg, r_p_crb;
    logic [PW-1:0] n_p_yr, n_p_yg, n_p_yb;
    logic [PW-1:0] n_p_cbr, n_p_cbg, n_p_cbb;
    logic [PW-1:0] n_p_crr, n_p_crg, n_p_crb;

    logic [SW-1:0] y_sum, cb_pos, cb_neg, cr_pos, cr_neg, cb_diff, cr_diff;
    logic [PIX_W-1:0] n_luma, n_cb, n_cr;
    logic [PIX_W-1:0] r_luma, r_cb, r_cr;

    // Stage one: constant products
    always_comb begin
        n_p_yr  = PW'(K_YR)   * PW'(i_red);
        n_p_yg  = PW'(K_YG)   * PW'(i_green);
        n_p_yb  = PW'(K_YB)   * PW'(i_blue);
        n_p_cbr = PW'(K_CBR)  * PW'(i_red);
        n_p_cbg = PW'(K_CBG)  * PW'(i_green);
        n_p_cbb = PW'(K_HALF) * PW'(i_blue);
        n_p_crr = PW'(K_HALF) * PW'(i_red);
        n_p_crg = PW'(K_CRG)  * PW'(i_green);
        n_p_crb = PW'(K_CRB)  * PW'(i_blue);
    end

    // Stage two: sum, floor and clamp each channel
    always_comb begin
        y_sum   = SW'(r_p_yr) + SW'(r_p_yg) + SW'(r_p_yb);
        cb_pos  = SW'(r_p_cbb) + OFFSET;
        cb_neg  = SW'(r_p_cbr) + SW'(r_p_cbg);
        cr_pos  = SW'(r_p_crr) + OFFSET;
        cr_neg  = SW'(r_p_crg) + SW'(r_p_crb);
        cb_diff = cb_pos - cb_neg;
        cr_diff = cr_pos - cr_neg;
        n_luma  = f_sat(y_sum[SW-1:FRACTION_BITS]);
        n_cb    = (cb_neg >= cb_pos) ? '0 : f_sat(cb_diff[SW-1:FRACTION_BITS]);
        n_cr    = (cr_neg >= cr_pos) ? '0 : f_sat(cr_diff[SW-1:FRACTION_BITS]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.prod_load) begin
            r_p_yr  <= n_p_yr;
            r_p_yg  <= n_p_yg;
            r_p_yb  <= n_p_yb;
            r_p_cbr <= n_p_cbr;
            r_p_cbg <= n_p_cbg;
            r_p_cbb <= n_p_cbb;
            r_p_crr <= n_p_crr;
            r_p_crg <= n_p_crg;
            r_p_crb <= n_p_crb;
        end
        if (i_en.res_load) begin
            r_luma <= n_luma;
            r_cb   <= n_cb;
            r_cr   <= n_cr;
        end
    end

    assign o_luma = r_luma;
    assign o_cb   = r_cb;
    assign o_cr   = r_cr;

endmodule

>>> rtl/rgb_to_ycbcr_420_downsampler_unit.sv
// Top level of the streaming RGB to YCbCr 4:2:0 downsampler.
// Pipeline: stages s1, s2, s3, s4, then the output register that holds the result beat.
// Throughput: one pixel per cycle while o_res.ready allows; each stage has its own valid
//   bit and load enable, so a result waiting at the output still lets bubbles close up.
// Reset (i_rst_n low, synchronous): empties the pipeline, clears column, row parity and
//   held chroma, sets image_width to 640; the line store keeps its contents.
module rgb_to_ycbcr_420_downsampler_unit import ycc420_pkg::*; #(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [WIDTH_W-1:0] i_cfg_wdata,
    ycc420_pix_if.sink         i_pix,
    ycc420_res_if.source       o_res
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int EW         = (WIDTH_W > COL_W + 1) ? WIDTH_W : COL_W + 1;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [WIDTH_W-1:0] r_image_width;

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its contents move on
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_o_valid;
    logic en_out, en_s4, en_s3, en_s2, en_s1;
    logic in_beat;

    assign en_out  = !r_o_valid || o_res.ready;
    assign en_s4   = !r_s4_valid || en_out;
    assign en_s3   = !r_s3_valid || en_s4;
    assign en_s2   = !r_s2_valid || en_s3;
    assign en_s1   = !r_s1_valid || en_s2;
    assign in_beat = i_pix.valid && en_s1;

    assign i_pix.ready = en_s1;

    // ------------------------------------------------------------------
    // Raster position, tracked as each beat is accepted
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_col, n_col, col_now;
    logic             r_row_odd, n_row_odd, row_now;
    logic [EW-1:0]    width_eff;
    logic             row_end;
    t_pos             n_pos;
    logic [IDX_W-1:0] n_idx;

    always_comb begin
        // Frame start restarts at row 0, column 0 before this pixel is placed
        col_now = i_pix.frame_start ? '0 : r_col;
        row_now = i_pix.frame_start ? 1'b0 : r_row_odd;

        // Clamp the programmed width to 2..MAX_WIDTH
        width_eff = EW'(r_image_width);
        if (width_eff < EW'(2)) begin
            width_eff = EW'(2);
        end else if (width_eff > EW'(MAX_WIDTH)) begin
            width_eff = EW'(MAX_WIDTH);
        end

        // A column at or past the last one ends the row, also after the width shrank
        row_end = EW'(col_now) >= (width_eff - EW'(1));
        if (row_end) begin
            n_col     = '0;
            n_row_odd = !row_now;
        end else begin
            n_col     = col_now + COL_W'(1);
            n_row_odd = row_now;
        end

        n_pos.col_odd = col_now[0];
        n_pos.pair    = col_now[0] && ((col_now >> 1) < COL_W'(LINE_DEPTH));
        n_pos.row_odd = row_now;
        n_idx         = IDX_W'(col_now >> 1);
    end

    // ------------------------------------------------------------------
    // Pipeline payload
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_s1_red, r_s1_green, r_s1_blue;
    t_pos             r_s1_pos, r_s2_pos, r_s3_pos, r_s4_pos;
    logic [IDX_W-1:0] r_s1_idx, r_s2_idx, r_s3_idx;

    t_stage_en        csc_en;
    logic [PIX_W-1:0] csc_luma, csc_cb, csc_cr;

    assign csc_en.prod_load = en_s2;
    assign csc_en.res_load  = en_s3;

    ycc420_csc #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_csc (
        .i_clk   (i_clk),
        .i_en    (csc_en),
        .i_red   (r_s1_red),
        .i_green (r_s1_green),
        .i_blue  (r_s1_blue),
        .o_luma  (csc_luma),
        .o_cb    (csc_cb),
        .o_cr    (csc_cr)
    );

    // ------------------------------------------------------------------
    // Horizontal pairing and the line store
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_pend_cb, r_pend_cr;
    logic [SUM_W-1:0] n_cb_pair, n_cr_pair;
    logic [SUM_W-1:0] r_s4_cb_pair, r_s4_cr_pair;
    logic [PIX_W-1:0] r_s4_luma;
    logic             s3_move;
    logic             ram_we, ram_re;
    logic [LINE_W-1:0] ram_rdata;

    assign s3_move   = r_s3_valid && en_s4;
    assign n_cb_pair = SUM_W'(r_pend_cb) + SUM_W'(csc_cb);
    assign n_cr_pair = SUM_W'(r_pend_cr) + SUM_W'(csc_cr);
    // Even rows leave their pair sums; odd rows fetch them for the block
    assign ram_we    = s3_move && r_s3_pos.pair && !r_s3_pos.row_odd;
    assign ram_re    = s3_move && r_s3_pos.pair && r_s3_pos.row_odd;

    ycc420_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s3_idx),
        .i_wdata ({n_cr_pair, n_cb_pair}),
        .i_re    (ram_re),
        .i_raddr (r_s3_idx),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Block average at the output
    // ------------------------------------------------------------------
    logic             n_o_cv;
    logic [SUM_W:0]   cb_four, cr_four;
    logic [PIX_W-1:0] n_o_cb, n_o_cr;
    logic [PIX_W-1:0] r_o_luma, r_o_cb, r_o_cr;
    logic             r_o_cv;

    always_comb begin
        n_o_cv  = r_s4_pos.pair && r_s4_pos.row_odd;
        cb_four = (SUM_W+1)'(ram_rdata[SUM_W-1:0]) + (SUM_W+1)'(r_s4_cb_pair);
        cr_four = (SUM_W+1)'(ram_rdata[LINE_W-1:SUM_W]) + (SUM_W+1)'(r_s4_cr_pair);
        // Floor of the four-sample sum over four; drop chroma outside a block end
        n_o_cb  = n_o_cv ? cb_four[SUM_W:2] : '0;
        n_o_cr  = n_o_cv ? cr_four[SUM_W:2] : '0;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= WIDTH_W'(RESET_WIDTH);
            r_col         <= '0;
            r_row_odd     <= 1'b0;
            r_pend_cb     <= '0;
            r_pend_cr     <= '0;
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_s3_valid    <= 1'b0;
            r_s4_valid    <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_image_width <= i_cfg_wdata;
            end
            if (in_beat) begin
                r_col     <= n_col;
                r_row_odd <= n_row_odd;
            end
            // Hold the even-column chroma until its partner arrives
            if (s3_move && !r_s3_pos.col_odd) begin
                r_pend_cb <= csc_cb;
                r_pend_cr <= csc_cr;
            end
            if (en_s1) begin
                r_s1_valid <= i_pix.valid;
            end
            if (en_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (en_s3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (en_s4) begin
                r_s4_valid <= r_s3_valid;
            end
            if (en_out) begin
                r_o_valid <= r_s4_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: advance with their stage, no reset
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_red   <= i_pix.red;
            r_s1_green <= i_pix.green;
            r_s1_blue  <= i_pix.blue;
            r_s1_pos   <= n_pos;
            r_s1_idx   <= n_idx;
        end
        if (en_s2) begin
            r_s2_pos <= r_s1_pos;
            r_s2_idx <= r_s1_idx;
        end
        if (en_s3) begin
            r_s3_pos <= r_s2_pos;
            r_s3_idx <= r_s2_idx;
        end
        if (en_s4) begin
            r_s4_pos     <= r_s3_pos;
            r_s4_luma    <= csc_luma;
            r_s4_cb_pair <= n_cb_pair;
            r_s4_cr_pair <= n_cr_pair;
        end
        if (en_out) begin
            r_o_luma <= r_s4_luma;
            r_o_cv   <= n_o_cv;
            r_o_cb   <= n_o_cb;
            r_o_cr   <= n_o_cr;
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.luma         = r_o_luma;
    assign o_res.chroma_valid = r_o_cv;
    assign o_res.cb_average   = r_o_cb;
    assign o_res.cr_average   = r_o_cr;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // One pixel either stores its pair sum or fetches one, never both
    a_line_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("line store written and read in the same cycle");

    // Input stalls only when every stage is full and the output beat is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_o_valid && !o_res.ready && r_s1_valid && r_s4_valid))
        else $error("input stalled with room in the pipeline");

    // Column counter never leaves the widest row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EW'(r_col) < EW'(MAX_WIDTH))
        else $error("column counter out of range");

    // Chroma fields read zero on beats that close no block
    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_cv) |-> (r_o_cb == '0 && r_o_cr == '0))
        else $error("chroma present on a beat without a block");

endmodule
